// ----- rtl/prt_pkg.sv -----
// Shared types, constants and the arctangent table for the polygon rotate and translate block.
// Used by prt_ctrl, prt_datapath and polygon_rotate_translate. Depends on nothing else.
package prt_pkg;

    localparam int MAX_POINTS_DEF     = 16;
    localparam int TRIG_FRAC_BITS_DEF = 15;

    localparam int COORD_W   = 16;
    localparam int ANGLE_W   = 16;
    localparam int OUT_IDX_W = 4;

    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_FRAC  = 30;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);
    localparam int RES_W        = ANGLE_W - 2;
    localparam int Z_SHIFT      = 32 - ANGLE_W;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);

    typedef enum logic [1:0] {
        KIND_DEFINE   = 2'd0,
        KIND_POSITION = 2'd1,
        KIND_COMMIT   = 2'd2,
        KIND_READ     = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_TRIG,
        ST_PT_READ,
        ST_PT_MUL,
        ST_PT_SUM,
        ST_PT_EMIT,
        ST_RD_READ,
        ST_RD_EMIT,
        ST_CM_READ,
        ST_CM_WRITE
    } state_t;

    typedef struct packed {
        kind_t                      kind;
        logic                       first;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
        logic signed [COORD_W-1:0]  origin_x;
        logic signed [COORD_W-1:0]  origin_y;
        logic        [ANGLE_W-1:0]  angle;
    } in_item_t;

    typedef struct packed {
        logic        [OUT_IDX_W-1:0] index;
        logic signed [COORD_W-1:0]   out_x;
        logic signed [COORD_W-1:0]   out_y;
        logic                        last;
    } out_item_t;

    typedef struct packed {
        logic                  cordic_init;
        logic                  cordic_step;
        logic [ITER_W-1:0]     iter;
        logic                  trig_load;
        logic                  mul_en;
        logic                  sum_en;
        logic                  def_we;
        logic                  tent_we;
        logic                  act_we;
        logic                  out_load;
        logic                  out_from_act;
        logic [OUT_IDX_W-1:0]  out_index;
        logic                  out_last;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [CORDIC_W-1:0] atan_turn(input logic [ITER_W-1:0] i);
        logic [CORDIC_W-1:0] v;
        unique case (i)
            5'd0:    v = CORDIC_W'(536870912);
            5'd1:    v = CORDIC_W'(316933406);
            5'd2:    v = CORDIC_W'(167458907);
            5'd3:    v = CORDIC_W'(85004756);
            5'd4:    v = CORDIC_W'(42667334);
            5'd5:    v = CORDIC_W'(21354464);
            5'd6:    v = CORDIC_W'(10679839);
            5'd7:    v = CORDIC_W'(5340245);
            5'd8:    v = CORDIC_W'(2670163);
            5'd9:    v = CORDIC_W'(1335087);
            5'd10:   v = CORDIC_W'(667544);
            5'd11:   v = CORDIC_W'(333772);
            5'd12:   v = CORDIC_W'(166886);
            5'd13:   v = CORDIC_W'(83443);
            5'd14:   v = CORDIC_W'(41722);
            5'd15:   v = CORDIC_W'(20861);
            5'd16:   v = CORDIC_W'(10430);
            5'd17:   v = CORDIC_W'(5215);
            5'd18:   v = CORDIC_W'(2608);
            5'd19:   v = CORDIC_W'(1304);
            5'd20:   v = CORDIC_W'(652);
            5'd21:   v = CORDIC_W'(326);
            5'd22:   v = CORDIC_W'(163);
            5'd23:   v = CORDIC_W'(81);
            5'd24:   v = CORDIC_W'(41);
            5'd25:   v = CORDIC_W'(20);
            5'd26:   v = CORDIC_W'(10);
            5'd27:   v = CORDIC_W'(5);
            5'd28:   v = CORDIC_W'(3);
            5'd29:   v = CORDIC_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/prt_ctrl.sv -----
// Sequencer for the polygon rotate and translate block: point count, walk index and CORDIC count.
// Depends on prt_pkg; drives the command struct read by prt_datapath.
module prt_ctrl #(
    parameter int MAX_POINTS = prt_pkg::MAX_POINTS_DEF,
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int CNTW = $clog2(MAX_POINTS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  prt_pkg::kind_t    kind,
    input  logic              first,
    input  prt_pkg::status_t  status,
    output prt_pkg::cmd_t     cmd,
    output logic [IW-1:0]     addr
);

    prt_pkg::state_t              state_reg, state_next;
    logic [CNTW-1:0]              count_reg, count_next;
    logic [CNTW-1:0]              idx_reg, idx_next;
    logic [prt_pkg::ITER_W-1:0]   iter_reg, iter_next;
    logic                         is_last;

    assign is_last = (({1'b0, idx_reg} + (CNTW + 1)'(1)) == {1'b0, count_reg});

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= prt_pkg::ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        iter_next  = iter_reg;
        in_ready   = 1'b0;
        addr       = idx_reg[IW-1:0];
        cmd           = '0;
        cmd.iter      = iter_reg;
        cmd.out_index = prt_pkg::OUT_IDX_W'(idx_reg);
        cmd.out_last  = is_last;

        unique case (state_reg)
            prt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                addr     = first ? '0 : count_reg[IW-1:0];
                idx_next = '0;
                if (in_valid)
                begin
                    unique case (kind)
                        prt_pkg::KIND_DEFINE:
                        begin
                            if (first)
                            begin
                                cmd.def_we = 1'b1;
                                count_next = CNTW'(1);
                            end else if (count_reg < CNTW'(MAX_POINTS))
                            begin
                                cmd.def_we = 1'b1;
                                count_next = count_reg + CNTW'(1);
                            end
                        end
                        prt_pkg::KIND_POSITION:
                        begin
                            if (count_reg != '0)
                            begin
                                cmd.cordic_init = 1'b1;
                                iter_next       = '0;
                                state_next      = prt_pkg::ST_CORDIC;
                            end
                        end
                        prt_pkg::KIND_COMMIT:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = prt_pkg::ST_CM_READ;
                            end
                        end
                        prt_pkg::KIND_READ:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = prt_pkg::ST_RD_READ;
                            end
                        end
                    endcase
                end
            end
            prt_pkg::ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                iter_next       = iter_reg + prt_pkg::ITER_W'(1);
                if (iter_reg == prt_pkg::ITER_W'(prt_pkg::CORDIC_ITERS - 1))
                begin
                    state_next = prt_pkg::ST_TRIG;
                end
            end
            prt_pkg::ST_TRIG:
            begin
                cmd.trig_load = 1'b1;
                state_next    = prt_pkg::ST_PT_READ;
            end
            prt_pkg::ST_PT_READ:
            begin
                state_next = prt_pkg::ST_PT_MUL;
            end
            prt_pkg::ST_PT_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = prt_pkg::ST_PT_SUM;
            end
            prt_pkg::ST_PT_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = prt_pkg::ST_PT_EMIT;
            end
            prt_pkg::ST_PT_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.tent_we  = 1'b1;
                    cmd.out_load = 1'b1;
                    if (is_last)
                    begin
                        state_next = prt_pkg::ST_IDLE;
                    end else
                    begin
                        idx_next   = idx_reg + CNTW'(1);
                        state_next = prt_pkg::ST_PT_READ;
                    end
                end
            end
            prt_pkg::ST_RD_READ:
            begin
                state_next = prt_pkg::ST_RD_EMIT;
            end
            prt_pkg::ST_RD_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_from_act = 1'b1;
                    if (is_last)
                    begin
                        state_next = prt_pkg::ST_IDLE;
                    end else
                    begin
                        idx_next   = idx_reg + CNTW'(1);
                        state_next = prt_pkg::ST_RD_READ;
                    end
                end
            end
            prt_pkg::ST_CM_READ:
            begin
                state_next = prt_pkg::ST_CM_WRITE;
            end
            prt_pkg::ST_CM_WRITE:
            begin
                cmd.act_we = 1'b1;
                if (is_last)
                begin
                    state_next = prt_pkg::ST_IDLE;
                end else
                begin
                    idx_next   = idx_reg + CNTW'(1);
                    state_next = prt_pkg::ST_CM_READ;
                end
            end
        endcase
    end

endmodule

// ----- rtl/prt_datapath.sv -----
// Datapath: point stores, iterative CORDIC, per-point multiply-add and the output register.
// Depends on prt_pkg; steered by the command struct from prt_ctrl.
module prt_datapath #(
    parameter int MAX_POINTS = prt_pkg::MAX_POINTS_DEF,
    parameter int TRIG_FRAC_BITS = prt_pkg::TRIG_FRAC_BITS_DEF,
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  prt_pkg::in_item_t   in_data,
    input  prt_pkg::cmd_t       cmd,
    input  logic [IW-1:0]       addr,
    output prt_pkg::status_t    status,
    output logic                out_valid,
    input  logic                out_ready,
    output prt_pkg::out_item_t  out_data
);

    localparam int F      = TRIG_FRAC_BITS;
    localparam int CW     = prt_pkg::CORDIC_W;
    localparam int SH     = prt_pkg::CORDIC_FRAC - F;
    localparam int RND_SH = (SH > 0) ? SH - 1 : 0;
    localparam int TW     = F + 2;
    localparam int PW     = prt_pkg::COORD_W + TW;
    localparam int SW     = PW + 2;

    localparam logic signed [CW-1:0] RND    = (SH > 0) ? (CW'(1) << RND_SH) : '0;
    localparam logic signed [CW-1:0] UNIT   = CW'(1) << F;
    localparam logic signed [CW-1:0] NUNIT  = -UNIT;
    localparam logic signed [TW-1:0] TRIG_ONE = TW'(1) << F;
    localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-32768);

    typedef struct packed {
        logic signed [prt_pkg::COORD_W-1:0] x;
        logic signed [prt_pkg::COORD_W-1:0] y;
    } pair_t;

    pair_t def_mem  [MAX_POINTS];
    pair_t tent_mem [MAX_POINTS];
    pair_t act_mem  [MAX_POINTS];

    pair_t def_rd_reg, tent_rd_reg, act_rd_reg;
    logic  tent_rv_reg, act_rv_reg;
    logic [MAX_POINTS-1:0] tent_valid_reg, act_valid_reg;
    pair_t tent_masked, act_masked, fin_pair, out_pair;

    logic signed [prt_pkg::COORD_W-1:0] ox_reg, oy_reg;
    logic        [prt_pkg::ANGLE_W-1:0] angle_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [CW-1:0] cx_next, cy_next, cz_next;
    logic signed [CW-1:0] shx, shy;
    logic        [CW-1:0] atan_val;
    logic signed [TW-1:0] cos_reg, sin_reg, cos_next, sin_next, cr, sr;
    logic                 res_zero;
    logic signed [PW-1:0] pxc_reg, pys_reg, pyc_reg, pxs_reg;
    logic signed [SW-1:0] sumx_reg, sumy_reg;
    logic                 out_valid_reg, out_valid_next;
    prt_pkg::out_item_t   out_data_reg;

    function automatic logic signed [TW-1:0] to_frac(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = (v + RND) >>> SH;
        if (r > UNIT)
        begin
            r = UNIT;
        end else if (r < NUNIT)
        begin
            r = NUNIT;
        end
        return TW'(r);
    endfunction

    // Divide by 2^F rounding toward zero, then saturate to the coordinate range.
    function automatic logic signed [prt_pkg::COORD_W-1:0] finish_coord(
        input logic signed [SW-1:0] acc
    );
        logic signed [SW-1:0] q;
        q = acc >>> F;
        if (acc[SW-1] && (|acc[F-1:0]))
        begin
            q = q + SW'(1);
        end
        if (q > SAT_HI)
        begin
            q = SAT_HI;
        end else if (q < SAT_LO)
        begin
            q = SAT_LO;
        end
        return prt_pkg::COORD_W'(q);
    endfunction

    // One CORDIC rotation per cycle.
    always_comb begin
        shx      = cy_reg >>> cmd.iter;
        shy      = cx_reg >>> cmd.iter;
        atan_val = prt_pkg::atan_turn(cmd.iter);
        if (!cz_reg[CW-1])
        begin
            cx_next = cx_reg - shx;
            cy_next = cy_reg + shy;
            cz_next = cz_reg - atan_val;
        end else
        begin
            cx_next = cx_reg + shx;
            cy_next = cy_reg - shy;
            cz_next = cz_reg + atan_val;
        end
    end

    always_comb begin
        res_zero = (angle_reg[prt_pkg::RES_W-1:0] == '0);
        cr = res_zero ? TRIG_ONE : to_frac(cx_reg);
        sr = res_zero ? '0 : to_frac(cy_reg);
        unique case (angle_reg[prt_pkg::ANGLE_W-1:prt_pkg::RES_W])
            2'd0:
            begin
                cos_next = cr;
                sin_next = sr;
            end
            2'd1:
            begin
                cos_next = -sr;
                sin_next = cr;
            end
            2'd2:
            begin
                cos_next = -cr;
                sin_next = -sr;
            end
            default:
            begin
                cos_next = sr;
                sin_next = -cr;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (cmd.cordic_init)
        begin
            cx_reg    <= prt_pkg::CORDIC_GAIN;
            cy_reg    <= '0;
            cz_reg    <= CW'(in_data.angle[prt_pkg::RES_W-1:0]) << prt_pkg::Z_SHIFT;
            ox_reg    <= in_data.origin_x;
            oy_reg    <= in_data.origin_y;
            angle_reg <= in_data.angle;
        end else if (cmd.cordic_step)
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            cz_reg <= cz_next;
        end
        if (cmd.trig_load)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
        if (cmd.mul_en)
        begin
            pxc_reg <= PW'(def_rd_reg.x) * PW'(cos_reg);
            pys_reg <= PW'(def_rd_reg.y) * PW'(sin_reg);
            pyc_reg <= PW'(def_rd_reg.y) * PW'(cos_reg);
            pxs_reg <= PW'(def_rd_reg.x) * PW'(sin_reg);
        end
        if (cmd.sum_en)
        begin
            sumx_reg <= SW'(pxc_reg) + SW'(pys_reg) + (SW'(ox_reg) <<< F);
            sumy_reg <= SW'(pyc_reg) - SW'(pxs_reg) + (SW'(oy_reg) <<< F);
        end
    end

    assign fin_pair.x  = finish_coord(sumx_reg);
    assign fin_pair.y  = finish_coord(sumy_reg);
    assign tent_masked = tent_rv_reg ? tent_rd_reg : '0;
    assign act_masked  = act_rv_reg ? act_rd_reg : '0;
    assign out_pair    = cmd.out_from_act ? act_masked : fin_pair;

    always_ff @(posedge clk) begin
        if (cmd.def_we)
        begin
            def_mem[addr] <= '{x: in_data.point_x, y: in_data.point_y};
        end
        if (cmd.tent_we)
        begin
            tent_mem[addr] <= fin_pair;
        end
        if (cmd.act_we)
        begin
            act_mem[addr] <= tent_masked;
        end
        def_rd_reg  <= def_mem[addr];
        tent_rd_reg <= tent_mem[addr];
        act_rd_reg  <= act_mem[addr];
    end

    always_comb begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            tent_valid_reg <= '0;
            act_valid_reg  <= '0;
            tent_rv_reg    <= 1'b0;
            act_rv_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else
        begin
            if (cmd.tent_we)
            begin
                tent_valid_reg[addr] <= 1'b1;
            end
            if (cmd.act_we)
            begin
                act_valid_reg[addr] <= 1'b1;
            end
            tent_rv_reg   <= tent_valid_reg[addr];
            act_rv_reg    <= act_valid_reg[addr];
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.out_load)
        begin
            out_data_reg <= '{index: cmd.out_index, out_x: out_pair.x,
                              out_y: out_pair.y, last: cmd.out_last};
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

// ----- rtl/polygon_rotate_translate.sv -----
// Top level of the polygon rotate and translate block.
// Depends on prt_pkg, prt_ctrl and prt_datapath.
//
//   Channel   Signals                         Beat content
//   in        in_valid, in_ready, in_data     one define, position, commit or read item
//   out       out_valid, out_ready, out_data  one transformed or stored point
//
// A define item is stored as it is accepted, while the store has room. A position item
// runs the iterative CORDIC (one rotation per cycle), then forms cos and sin, then takes a
// memory read, multiply, add and output step per point. Commit and read items take a read
// and then a write or output step per point, through the single read port of each store.
// Reset clears the point count, the valid bits of the tentative and actual stores and the
// output valid. A stalled output holds the walk in its output step; the last beat of a run
// may wait in the output register while the next item is already accepted.
module polygon_rotate_translate #(
    parameter int MAX_POINTS = prt_pkg::MAX_POINTS_DEF,
    parameter int TRIG_FRAC_BITS = prt_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  prt_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output prt_pkg::out_item_t  out_data
);

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    prt_pkg::cmd_t    ctl_cmd;
    prt_pkg::status_t ctl_status;
    logic [IW-1:0]    ctl_addr;

    prt_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (in_data.kind),
        .first    (in_data.first),
        .status   (ctl_status),
        .cmd      (ctl_cmd),
        .addr     (ctl_addr)
    );

    prt_datapath #(
        .MAX_POINTS     (MAX_POINTS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (ctl_cmd),
        .addr      (ctl_addr),
        .status    (ctl_status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.out_load |-> !ctl_status.out_busy)
        else $error("Output register loaded while a stalled beat was waiting.");

    a_def_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.def_we |-> (in_valid && in_ready))
        else $error("Definition store written without an accepted input beat.");

    a_tent_emitted: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.tent_we |-> (ctl_cmd.out_load && !ctl_cmd.out_from_act))
        else $error("Tentative point written without being emitted.");

    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctl_cmd.out_load))
        else $error("Output valid rose without a load command.");
`endif

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for polygon_rotate_translate: define, position, commit and read beats
// with random idling on both channels, checked against a cycle-free model of the point stores.
// Depends on prt_pkg and the RTL of polygon_rotate_translate.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS = prt_pkg::MAX_POINTS_DEF;
    localparam int FRAC = prt_pkg::TRIG_FRAC_BITS_DEF;
    localparam int SH = prt_pkg::CORDIC_FRAC - FRAC;
    localparam int N_RANDOM = 100;
    localparam int TAIL_CYCLES = 200;
    localparam longint GAIN_Q30 = 652032874;
    localparam longint ATAN_TAB [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667334, 21354464,
        10679839, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    typedef struct {
        prt_pkg::in_item_t item;
        bit                drain_first;
    } send_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    prt_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    prt_pkg::out_item_t out_data;

    send_t              items_to_send [$];
    prt_pkg::out_item_t points_due [$];
    prt_pkg::out_item_t want;

    int unsigned        list_len = 0;
    logic signed [15:0] def_x [NPTS];
    logic signed [15:0] def_y [NPTS];
    logic signed [15:0] tent_x [NPTS];
    logic signed [15:0] tent_y [NPTS];
    logic signed [15:0] act_x [NPTS];
    logic signed [15:0] act_y [NPTS];

    logic in_taken = 1'b0;
    logic calm = 1'b0;
    int   in_gap = 0;
    int   out_stall = 0;
    int   errors = 0;

    polygon_rotate_translate u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint to_q(input longint v);
        longint r;
        r = (v + (longint'(1) << (SH - 1))) >>> SH;
        if (r > (longint'(1) << FRAC))
            r = longint'(1) << FRAC;
        if (r < -(longint'(1) << FRAC))
            r = -(longint'(1) << FRAC);
        return r;
    endfunction

    function automatic logic signed [prt_pkg::COORD_W-1:0] trunc_sat(input longint acc);
        longint v;
        v = acc / (longint'(1) << FRAC);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return prt_pkg::COORD_W'(v);
    endfunction

    task automatic rotate_translate_item(input prt_pkg::in_item_t it);
        longint             x, y, z, dx, dy, cr, sr, c, s, px, py, ox, oy;
        int                 i;
        prt_pkg::out_item_t p;
        case (it.kind)
            prt_pkg::KIND_DEFINE:
            begin
                if (it.first)
                    list_len = 0;
                if (list_len < NPTS)
                begin
                    def_x[list_len] = it.point_x;
                    def_y[list_len] = it.point_y;
                    list_len++;
                end
            end
            prt_pkg::KIND_POSITION:
            begin
                if (it.angle[prt_pkg::RES_W-1:0] == '0)
                begin
                    cr = longint'(1) << FRAC;
                    sr = 0;
                end
                else
                begin
                    x = GAIN_Q30;
                    y = 0;
                    z = longint'(it.angle[prt_pkg::RES_W-1:0]) << prt_pkg::Z_SHIFT;
                    for (i = 0; i < prt_pkg::CORDIC_ITERS; i++)
                    begin
                        dx = y >>> i;
                        dy = x >>> i;
                        if (z >= 0)
                        begin
                            x -= dx;
                            y += dy;
                            z -= ATAN_TAB[i];
                        end
                        else
                        begin
                            x += dx;
                            y -= dy;
                            z += ATAN_TAB[i];
                        end
                    end
                    cr = to_q(x);
                    sr = to_q(y);
                end
                case (it.angle[prt_pkg::ANGLE_W-1:prt_pkg::RES_W])
                    2'd0:
                    begin
                        c = cr;
                        s = sr;
                    end
                    2'd1:
                    begin
                        c = -sr;
                        s = cr;
                    end
                    2'd2:
                    begin
                        c = -cr;
                        s = -sr;
                    end
                    default:
                    begin
                        c = sr;
                        s = -cr;
                    end
                endcase
                ox = longint'($signed(it.origin_x)) << FRAC;
                oy = longint'($signed(it.origin_y)) << FRAC;
                for (i = 0; i < list_len; i++)
                begin
                    px = longint'(def_x[i]);
                    py = longint'(def_y[i]);
                    tent_x[i] = trunc_sat(px * c + py * s + ox);
                    tent_y[i] = trunc_sat(py * c - px * s + oy);
                end
            end
            prt_pkg::KIND_COMMIT:
            begin
                for (i = 0; i < list_len; i++)
                begin
                    act_x[i] = tent_x[i];
                    act_y[i] = tent_y[i];
                end
            end
            default:
            begin
            end
        endcase
        if (it.kind == prt_pkg::KIND_POSITION || it.kind == prt_pkg::KIND_READ)
        begin
            for (i = 0; i < list_len; i++)
            begin
                p.index = prt_pkg::OUT_IDX_W'(i);
                p.out_x = (it.kind == prt_pkg::KIND_POSITION) ? tent_x[i] : act_x[i];
                p.out_y = (it.kind == prt_pkg::KIND_POSITION) ? tent_y[i] : act_y[i];
                p.last = (i + 1 == list_len);
                points_due.push_back(p);
            end
        end
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic prt_pkg::in_item_t rand_item(input prt_pkg::kind_t k);
        prt_pkg::in_item_t it;
        it.kind = k;
        it.first = 1'($urandom);
        it.point_x = pick_coord();
        it.point_y = pick_coord();
        it.origin_x = pick_coord();
        it.origin_y = pick_coord();
        case ($urandom_range(0, 9))
            0, 1: it.angle = {2'($urandom), 14'h0000};
            2: it.angle = {2'($urandom), 14'h0001};
            3: it.angle = {2'($urandom), 14'h3FFF};
            default: it.angle = 16'($urandom);
        endcase
        return it;
    endfunction

    function automatic prt_pkg::in_item_t make_item(input prt_pkg::kind_t k, input logic f,
                                                    input int px, input int py,
                                                    input int ox, input int oy,
                                                    input int ang);
        prt_pkg::in_item_t it;
        it.kind = k;
        it.first = f;
        it.point_x = 16'(px);
        it.point_y = 16'(py);
        it.origin_x = 16'(ox);
        it.origin_y = 16'(oy);
        it.angle = 16'(ang);
        return it;
    endfunction

    task automatic push(input prt_pkg::in_item_t it, input bit drain);
        send_t e;
        e.item = it;
        e.drain_first = drain;
        items_to_send.push_back(e);
    endtask

    // Driver: input and output handshake signals change only at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 299) == 0)
                calm <= !calm;
            if (in_valid && !in_taken)
            begin
            end
            else if (in_gap != 0 && !calm)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (items_to_send.size() == 0 ||
                     (items_to_send[0].drain_first && points_due.size() != 0))
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                in_data <= items_to_send[0].item;
                in_valid <= 1'b1;
                in_gap <= idle_len();
                void'(items_to_send.pop_front());
            end
            if (out_stall != 0 && !calm)
            begin
                out_ready <= 1'b0;
                out_stall <= out_stall - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                out_stall <= idle_len();
            end
        end
    end

    // Monitor: every accepted input beat updates the model, every output beat is checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
                rotate_translate_item(in_data);
            if (out_valid && out_ready)
            begin
                if (points_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected beat: index %0d x %0d y %0d last %0b",
                                 out_data.index, out_data.out_x, out_data.out_y,
                                 out_data.last);
                end
                else
                begin
                    want = points_due.pop_front();
                    if (out_data.index !== want.index || out_data.out_x !== want.out_x ||
                        out_data.out_y !== want.out_y || out_data.last !== want.last)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $write("beat mismatch: expected index %0d x %0d y %0d last %0b, ",
                                   want.index, want.out_x, want.out_y, want.last);
                            $display("got index %0d x %0d y %0d last %0b",
                                     out_data.index, out_data.out_x, out_data.out_y,
                                     out_data.last);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        prt_pkg::in_item_t it;
        int                n_rand;
        int                seq;
        int                len;
        int                j;
        int unsigned       shadow;
        for (j = 0; j < NPTS; j++)
        begin
            tent_x[j] = '0;
            tent_y[j] = '0;
            act_x[j] = '0;
            act_y[j] = '0;
        end

        push(make_item(prt_pkg::KIND_POSITION, 1'b0, 0, 0, 100, -100, 16'h1234), 1'b0);
        push(make_item(prt_pkg::KIND_COMMIT, 1'b0, 0, 0, 0, 0, 0), 1'b0);
        push(make_item(prt_pkg::KIND_READ, 1'b0, 0, 0, 0, 0, 0), 1'b0);
        push(make_item(prt_pkg::KIND_DEFINE, 1'b1, 32767, 32767, 0, 0, 0), 1'b0);
        push(make_item(prt_pkg::KIND_DEFINE, 1'b0, -32768, -32768, 0, 0, 0), 1'b0);
        push(make_item(prt_pkg::KIND_DEFINE, 1'b0, 32767, -32768, 0, 0, 0), 1'b0);
        push(make_item(prt_pkg::KIND_DEFINE, 1'b0, -32768, 32767, 0, 0, 0), 1'b0);
        push(make_item(prt_pkg::KIND_DEFINE, 1'b0, 1, -1, 0, 0, 0), 1'b0);
        push(make_item(prt_pkg::KIND_READ, 1'b0, 0, 0, 0, 0, 0), 1'b0);
        push(make_item(prt_pkg::KIND_POSITION, 1'b0, 0, 0, 32767, 32767, 16'h0000), 1'b0);
        push(make_item(prt_pkg::KIND_POSITION, 1'b0, 0, 0, -32768, -32768, 16'h2000), 1'b0);
        push(make_item(prt_pkg::KIND_POSITION, 1'b0, 0, 0, 0, 0, 16'h4000), 1'b0);
        push(make_item(prt_pkg::KIND_POSITION, 1'b0, 0, 0, 0, 0, 16'h8000), 1'b0);
        push(make_item(prt_pkg::KIND_POSITION, 1'b0, 0, 0, 1234, -4321, 16'hC000), 1'b0);
        push(make_item(prt_pkg::KIND_POSITION, 1'b0, 0, 0, 0, 0, 16'h0001), 1'b0);
        push(make_item(prt_pkg::KIND_POSITION, 1'b0, 0, 0, 32767, -32768, 16'hFFFF), 1'b0);
        push(make_item(prt_pkg::KIND_COMMIT, 1'b0, 0, 0, 0, 0, 0), 1'b0);
        push(make_item(prt_pkg::KIND_READ, 1'b0, 0, 0, 0, 0, 0), 1'b0);
        push(make_item(prt_pkg::KIND_DEFINE, 1'b1, 0, 0, 0, 0, 0), 1'b0);
        push(make_item(prt_pkg::KIND_READ, 1'b0, 0, 0, 0, 0, 0), 1'b0);
        push(make_item(prt_pkg::KIND_POSITION, 1'b0, 0, 0, -7, 9, 16'h5555), 1'b1);
        push(make_item(prt_pkg::KIND_COMMIT, 1'b1, 0, 0, 0, 0, 0), 1'b0);
        push(make_item(prt_pkg::KIND_READ, 1'b0, 0, 0, 0, 0, 0), 1'b0);

        n_rand = 0;
        seq = 0;
        shadow = 1;
        while (n_rand < N_RANDOM)
        begin
            if (seq == 0 || $urandom_range(0, 9) < 8)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(1, 6);
                    6, 7, 8: len = $urandom_range(7, 15);
                    default: len = $urandom_range(NPTS, NPTS + 3);
                endcase
                if (seq == 0)
                    len = NPTS + 2;
                for (j = 0; j < len; j++)
                begin
                    it = rand_item(prt_pkg::KIND_DEFINE);
                    it.first = (j == 0) || ($urandom_range(0, 19) == 0);
                    push(it, 1'b0);
                    if (it.first)
                        shadow = 0;
                    if (shadow < NPTS)
                    begin
                        shadow++;
                        n_rand++;
                    end
                end
                repeat ($urandom_range(1, 3))
                begin
                    push(rand_item(prt_pkg::KIND_POSITION), $urandom_range(0, 24) == 0);
                    n_rand++;
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    push(rand_item(prt_pkg::KIND_COMMIT), 1'b0);
                    n_rand++;
                end
                if ($urandom_range(0, 2) != 0)
                begin
                    push(rand_item(prt_pkg::KIND_READ), 1'b0);
                    n_rand++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    it = rand_item(prt_pkg::kind_t'(2'($urandom_range(0, 3))));
                    push(it, 1'b0);
                    if (it.kind == prt_pkg::KIND_DEFINE && it.first)
                        shadow = 0;
                    if (it.kind != prt_pkg::KIND_DEFINE || shadow < NPTS)
                        n_rand++;
                    if (it.kind == prt_pkg::KIND_DEFINE && shadow < NPTS)
                        shadow++;
                end
            end
            seq++;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (items_to_send.size() != 0 || in_valid)
            @(negedge clk);
        while (points_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("polygon_rotate_translate verification clean");
        else
            $display("polygon_rotate_translate verification failed");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("polygon_rotate_translate verification failed");
        $finish;
    end

endmodule
